// ===== rtl/apmq_pkg.sv =====
// shared constants for the alarm priority message queue
// no dependencies; used by the top level and the testbench
`default_nettype none
package apmq_pkg;

  localparam int NORMAL_DEPTH = 16;
  localparam int MSG_WIDTH    = 32;

  localparam int PTR_W = (NORMAL_DEPTH > 1) ? $clog2(NORMAL_DEPTH) : 1;
  localparam int CNT_W = $clog2(NORMAL_DEPTH + 1);
  localparam int TOT_W = $clog2(NORMAL_DEPTH + 2);

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_NO_MSG  = 2'd2;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  localparam logic KIND_ALARM  = 1'b0;
  localparam logic KIND_NORMAL = 1'b1;

endpackage
`default_nettype wire

// ===== rtl/alarm_priority_message_queue.sv =====
// top level of the alarm priority message queue
// depends on apmq_pkg and apmq_ram
`default_nettype none
// usage
//   input channel: an item (in_cmd, in_kind, in_message) is taken at a rising
//   edge with start high and busy low. in_cmd selects send or receive; on a
//   send in_kind picks the alarm slot or the normal fifo.
//   result channel: exactly one result per item, shown on the out_ ports for
//   one cycle while out_valid is high, in the cycle after the item is taken.
//   the receiver cannot stall, so nothing is held back on the output side.
//   throughput: one item per cycle. busy stays low; the only stored path is
//   the normal-message ram, whose read is registered.
//   a receive always sees sends taken in earlier cycles, since the ram write
//   lands at the edge that takes the send and the read is issued later.
//   the alarm is always served before any normal message.
//   reset (synchronous, rst_n low) empties the alarm slot and the fifo and
//   drops any pending result. ram contents are not cleared; an entry is
//   only read after it was written.
module alarm_priority_message_queue (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_cmd,
  input  wire logic                               in_kind,
  input  wire logic [apmq_pkg::MSG_WIDTH-1:0]     in_message,
  output logic                                    out_valid,
  output logic      [1:0]                         out_status,
  output logic                                    out_served_kind,
  output logic      [apmq_pkg::MSG_WIDTH-1:0]     out_message_out,
  output logic      [apmq_pkg::TOT_W-1:0]         out_total_count,
  output logic                                    out_alarm_held
);

  localparam logic [apmq_pkg::CNT_W-1:0] FULL_CNT =
    apmq_pkg::CNT_W'(apmq_pkg::NORMAL_DEPTH);
  localparam logic [apmq_pkg::PTR_W-1:0] LAST_PTR =
    apmq_pkg::PTR_W'(apmq_pkg::NORMAL_DEPTH - 1);

  // control state
  logic                         alarm_valid_r, alarm_valid_nxt;
  logic [apmq_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [apmq_pkg::PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [apmq_pkg::PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // payload state
  logic [apmq_pkg::MSG_WIDTH-1:0] alarm_word_r, alarm_word_nxt;
  logic [1:0]                     status_r, status_nxt;
  logic                           kind_r, kind_nxt;
  logic [apmq_pkg::MSG_WIDTH-1:0] msg_r, msg_nxt;
  logic                           sel_ram_r, sel_ram_nxt;
  logic [apmq_pkg::TOT_W-1:0]     tot_r, tot_nxt;
  logic                           held_r, held_nxt;

  logic                           accept;
  logic                           is_send, is_recv;
  logic                           send_alarm_ok, send_norm_ok;
  logic                           recv_alarm, recv_norm;
  logic                           store_full, store_empty;
  logic [apmq_pkg::MSG_WIDTH-1:0] ram_rdata;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_send     = accept && (in_cmd == apmq_pkg::CMD_SEND);
  assign is_recv     = accept && (in_cmd == apmq_pkg::CMD_RECV);
  assign store_full  = (cnt_r == FULL_CNT);
  assign store_empty = (cnt_r == '0);

  assign send_alarm_ok = is_send && (in_kind == apmq_pkg::KIND_ALARM) && !alarm_valid_r;
  assign send_norm_ok  = is_send && (in_kind == apmq_pkg::KIND_NORMAL) && !store_full;
  // alarm wins over the fifo on a receive
  assign recv_alarm    = is_recv && alarm_valid_r;
  assign recv_norm     = is_recv && !alarm_valid_r && !store_empty;

  // normal-message store; read data shows up in the result cycle
  apmq_ram #(
    .WIDTH (apmq_pkg::MSG_WIDTH),
    .DEPTH (apmq_pkg::NORMAL_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (send_norm_ok),
    .waddr (wr_ptr_r),
    .wdata (in_message),
    .re    (recv_norm),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // queue state update
  always_comb begin
    alarm_valid_nxt = alarm_valid_r;
    alarm_word_nxt  = alarm_word_r;
    cnt_nxt         = cnt_r;
    rd_ptr_nxt      = rd_ptr_r;
    wr_ptr_nxt      = wr_ptr_r;
    if (send_alarm_ok) begin
      alarm_valid_nxt = 1'b1;
      alarm_word_nxt  = in_message;
    end
    if (recv_alarm) begin
      alarm_valid_nxt = 1'b0;
    end
    if (send_norm_ok) begin
      cnt_nxt    = cnt_r + 1'b1;
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (recv_norm) begin
      cnt_nxt    = cnt_r - 1'b1;
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
  end

  // result capture
  always_comb begin
    out_valid_nxt = accept;
    status_nxt    = apmq_pkg::ST_OK;
    if (is_send && !send_alarm_ok && !send_norm_ok) begin
      status_nxt = apmq_pkg::ST_NO_ROOM;
    end else if (is_recv && !recv_alarm && !recv_norm) begin
      status_nxt = apmq_pkg::ST_NO_MSG;
    end
    kind_nxt    = recv_norm ? apmq_pkg::KIND_NORMAL : apmq_pkg::KIND_ALARM;
    msg_nxt     = recv_alarm ? alarm_word_r : '0;
    sel_ram_nxt = recv_norm;
    tot_nxt     = apmq_pkg::TOT_W'(cnt_nxt) + apmq_pkg::TOT_W'(alarm_valid_nxt);
    held_nxt    = alarm_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alarm_valid_r <= 1'b0;
      cnt_r         <= '0;
      rd_ptr_r      <= '0;
      wr_ptr_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      alarm_valid_r <= alarm_valid_nxt;
      cnt_r         <= cnt_nxt;
      rd_ptr_r      <= rd_ptr_nxt;
      wr_ptr_r      <= wr_ptr_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    alarm_word_r <= alarm_word_nxt;
    status_r     <= status_nxt;
    kind_r       <= kind_nxt;
    msg_r        <= msg_nxt;
    sel_ram_r    <= sel_ram_nxt;
    tot_r        <= tot_nxt;
    held_r       <= held_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_served_kind = kind_r;
  assign out_message_out = sel_ram_r ? ram_rdata : msg_r;
  assign out_total_count = tot_r;
  assign out_alarm_held  = held_r;

  // fill count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("normal count above depth");

  // pointers and count stay consistent
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == FULL_CNT) |-> (rd_ptr_r == wr_ptr_r))
    else $error("pointers disagree with count");

  // a result appears only the cycle after an item was taken
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result without item");

  // an empty-queue status reports nothing held
  a_no_msg_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == apmq_pkg::ST_NO_MSG) |->
      (out_total_count == '0 && !out_alarm_held))
    else $error("no message reported with items held");

  // a normal message is never served while an alarm is waiting
  a_alarm_first: assert property (@(posedge clk) disable iff (!rst_n)
    recv_norm |-> !alarm_valid_r)
    else $error("normal served ahead of alarm");

endmodule
`default_nettype wire

// ===== rtl/apmq_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none
module apmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_alarm_priority_message_queue.sv =====
`timescale 1ns / 1ps
// self-checking testbench for alarm_priority_message_queue
// depends on apmq_pkg and the queue rtl; a clocked driver, monitor and in-line predictor
module tb_alarm_priority_message_queue;

  localparam int NUM_ITEMS    = 1750;
  localparam int NO_IDLE_LO   = 700;    // accepted-item window with no random idle cycles
  localparam int NO_IDLE_HI   = 1000;
  localparam int IDLE_PCT     = 37;
  localparam int DRAIN_GAP    = 3;      // quiet cycles before a held-off item goes out
  localparam int TAIL_CYCLES  = 4;
  localparam realtime RUN_LIMIT = 200000ns;

  // one send or receive as the driver presents it
  typedef struct packed {
    logic                           cmd;
    logic                           kind;
    logic [apmq_pkg::MSG_WIDTH-1:0] message;
    logic                           hold;          // wait for the queue to go quiet first
  } queue_op_t;

  // what the block reports for one item
  typedef struct packed {
    logic [1:0]                     status;
    logic                           served_kind;
    logic [apmq_pkg::MSG_WIDTH-1:0] message_out;
    logic [apmq_pkg::TOT_W-1:0]     total_count;
    logic                           alarm_held;
  } queue_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_cmd = apmq_pkg::CMD_SEND;
  logic in_kind = apmq_pkg::KIND_ALARM;
  logic [apmq_pkg::MSG_WIDTH-1:0] in_message = '0;
  logic busy;
  logic out_valid;
  logic [1:0] out_status;
  logic out_served_kind;
  logic [apmq_pkg::MSG_WIDTH-1:0] out_message_out;
  logic [apmq_pkg::TOT_W-1:0] out_total_count;
  logic out_alarm_held;

  alarm_priority_message_queue uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_kind         (in_kind),
    .in_message      (in_message),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_served_kind (out_served_kind),
    .out_message_out (out_message_out),
    .out_total_count (out_total_count),
    .out_alarm_held  (out_alarm_held)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // reset held low while rst_cycles counts up, then released for good
  int rst_cycles = 0;
  always @(posedge clk) begin
    if (rst_cycles < 12) begin
      rst_cycles <= rst_cycles + 1;
      if (rst_cycles == 11) begin
        rst_n <= 1'b1;
      end
    end
  end

  queue_op_t     op_queue[$];          // items not yet presented
  queue_status_t expected_status_q[$]; // predicted results in arrival order
  int            n_err = 0;

  // shadow copy of the queue state
  logic [apmq_pkg::MSG_WIDTH-1:0] alarm_slot;
  logic                           alarm_full = 1'b0;
  logic [apmq_pkg::MSG_WIDTH-1:0] fifo_mem [apmq_pkg::NORMAL_DEPTH];
  logic [apmq_pkg::PTR_W-1:0]     fifo_rd = '0;
  logic [apmq_pkg::PTR_W-1:0]     fifo_wr = '0;
  logic [apmq_pkg::CNT_W-1:0]     fifo_level = '0;

  task automatic report_mismatch(input string what,
                                 input logic [apmq_pkg::MSG_WIDTH-1:0] got,
                                 input logic [apmq_pkg::MSG_WIDTH-1:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    n_err++;
  endtask

  // one step of the queue: alarm first, then the oldest normal message
  task automatic model_queue_op(input queue_op_t op, output queue_status_t res);
    res = '0;
    res.status = apmq_pkg::ST_OK;
    if (op.cmd == apmq_pkg::CMD_SEND) begin
      if (op.kind == apmq_pkg::KIND_ALARM) begin
        // only one alarm can be held
        if (alarm_full) begin
          res.status = apmq_pkg::ST_NO_ROOM;
        end else begin
          alarm_slot = op.message;
          alarm_full = 1'b1;
        end
      end else if (int'(fifo_level) == apmq_pkg::NORMAL_DEPTH) begin
        res.status = apmq_pkg::ST_NO_ROOM;
      end else begin
        fifo_mem[fifo_wr] = op.message;
        fifo_wr = (int'(fifo_wr) == apmq_pkg::NORMAL_DEPTH - 1) ? '0 : fifo_wr + 1'b1;
        fifo_level = fifo_level + 1'b1;
      end
    end else if (alarm_full) begin
      res.served_kind = apmq_pkg::KIND_ALARM;
      res.message_out = alarm_slot;
      alarm_full = 1'b0;
    end else if (fifo_level != 0) begin
      res.served_kind = apmq_pkg::KIND_NORMAL;
      res.message_out = fifo_mem[fifo_rd];
      fifo_rd = (int'(fifo_rd) == apmq_pkg::NORMAL_DEPTH - 1) ? '0 : fifo_rd + 1'b1;
      fifo_level = fifo_level - 1'b1;
    end else begin
      // nothing held
      res.status = apmq_pkg::ST_NO_MSG;
    end
    res.total_count = apmq_pkg::TOT_W'(fifo_level) + apmq_pkg::TOT_W'(alarm_full);
    res.alarm_held = alarm_full;
  endtask

  // driver: predicts each item at the edge that takes it, then picks what goes next
  queue_op_t     cur_op;
  queue_status_t pred;
  int            n_acc = 0;
  int            quiet = DRAIN_GAP;
  logic          idle_now;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        model_queue_op(cur_op, pred);
        expected_status_q.push_back(pred);
        n_acc++;
        quiet = 0;
      end else if (quiet < DRAIN_GAP) begin
        quiet++;
      end
      idle_now = (n_acc < NO_IDLE_LO || n_acc >= NO_IDLE_HI) &&
                 ($urandom_range(99) < IDLE_PCT);
      if (start && busy) begin
        // block not ready, keep the same item up
        start <= 1'b1;
      end else if (op_queue.size() == 0 ||
                   (op_queue[0].hold && (quiet < DRAIN_GAP || expected_status_q.size() != 0)) ||
                   idle_now) begin
        // idle cycle; data lines carry junk while start is low
        start      <= 1'b0;
        in_cmd     <= 1'($urandom_range(1));
        in_kind    <= 1'($urandom_range(1));
        in_message <= apmq_pkg::MSG_WIDTH'($urandom);
      end else begin
        cur_op = op_queue.pop_front();
        start      <= 1'b1;
        in_cmd     <= cur_op.cmd;
        in_kind    <= cur_op.kind;
        in_message <= cur_op.message;
      end
    end
  end

  // monitor: every strobed result is checked against the oldest prediction
  queue_status_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        report_mismatch("out_valid unknown", '0, '0);
      end else if (out_valid) begin
        if (expected_status_q.size() == 0) begin
          report_mismatch("result with no item pending", out_message_out, '0);
        end else begin
          want = expected_status_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", apmq_pkg::MSG_WIDTH'(out_status),
                            apmq_pkg::MSG_WIDTH'(want.status));
          if (out_served_kind !== want.served_kind)
            report_mismatch("served_kind", apmq_pkg::MSG_WIDTH'(out_served_kind),
                            apmq_pkg::MSG_WIDTH'(want.served_kind));
          if (out_message_out !== want.message_out)
            report_mismatch("message_out", out_message_out, want.message_out);
          if (out_total_count !== want.total_count)
            report_mismatch("total_count", apmq_pkg::MSG_WIDTH'(out_total_count),
                            apmq_pkg::MSG_WIDTH'(want.total_count));
          if (out_alarm_held !== want.alarm_held)
            report_mismatch("alarm_held", apmq_pkg::MSG_WIDTH'(out_alarm_held),
                            apmq_pkg::MSG_WIDTH'(want.alarm_held));
        end
      end
    end
  end

  task automatic add_op(input logic cmd, input logic kind,
                        input logic [apmq_pkg::MSG_WIDTH-1:0] msg, input logic hold);
    queue_op_t op;
    op.cmd = cmd;
    op.kind = kind;
    op.message = msg;
    op.hold = hold;
    op_queue.push_back(op);
  endtask

  // payload with the extremes mixed in
  function automatic logic [apmq_pkg::MSG_WIDTH-1:0] pick_word();
    int sel;
    sel = $urandom_range(15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return apmq_pkg::MSG_WIDTH'($urandom);
  endfunction

  // stimulus, then the end of the run
  int burst_sel;
  int burst_len;
  logic burst_hold;
  logic rand_kind;

  initial begin
    // receive on an empty queue, with junk on the ignored fields
    add_op(apmq_pkg::CMD_RECV, apmq_pkg::KIND_NORMAL, '1, 1'b0);
    // alarm slot: fill, overflow, serve, then empty again
    add_op(apmq_pkg::CMD_SEND, apmq_pkg::KIND_ALARM, '1, 1'b0);
    add_op(apmq_pkg::CMD_SEND, apmq_pkg::KIND_ALARM, '0, 1'b0);
    add_op(apmq_pkg::CMD_RECV, apmq_pkg::KIND_ALARM, 32'h5a5a_a5a5, 1'b0);
    add_op(apmq_pkg::CMD_RECV, apmq_pkg::KIND_ALARM, '0, 1'b0);
    // fill the normal store to the brim with walking patterns and extremes
    for (int i = 0; i < apmq_pkg::NORMAL_DEPTH; i++) begin
      add_op(apmq_pkg::CMD_SEND, apmq_pkg::KIND_NORMAL,
             (i == 0) ? '0 : (i == 1) ? '1 : (i < 10) ? (32'h1 << (i * 4 - 5)) :
             ~(32'h1 << (i * 2)), 1'b0);
    end
    // store full, then an alarm on top for the largest count
    add_op(apmq_pkg::CMD_SEND, apmq_pkg::KIND_NORMAL, 32'hdead_beef, 1'b0);
    add_op(apmq_pkg::CMD_SEND, apmq_pkg::KIND_ALARM, 32'h8000_0001, 1'b0);
    // alarm must jump the line
    add_op(apmq_pkg::CMD_RECV, apmq_pkg::KIND_NORMAL, '0, 1'b0);
    add_op(apmq_pkg::CMD_RECV, apmq_pkg::KIND_NORMAL, '0, 1'b0);

    // random bursts: fill runs, drain runs and mixed traffic so that the
    // store hits both full and empty and the pointers wrap many times
    burst_hold = 1'b1;
    while (op_queue.size() < NUM_ITEMS) begin
      burst_sel = $urandom_range(9);
      burst_len = $urandom_range(1, 24);
      for (int i = 0; i < burst_len; i++) begin
        rand_kind = ($urandom_range(5) == 0) ? apmq_pkg::KIND_ALARM : apmq_pkg::KIND_NORMAL;
        if (burst_sel < 4) begin
          add_op(apmq_pkg::CMD_SEND, rand_kind, pick_word(), burst_hold);
        end else if (burst_sel < 7) begin
          add_op(apmq_pkg::CMD_RECV, 1'($urandom_range(1)),
                 apmq_pkg::MSG_WIDTH'($urandom), burst_hold);
        end else begin
          add_op(1'($urandom_range(1)), 1'($urandom_range(1)), pick_word(), burst_hold);
        end
        burst_hold = 1'b0;
      end
      // now and then let the queue go quiet before the next burst
      burst_hold = ($urandom_range(29) == 0);
    end

    // everything presented and taken, every result back, then a short tail
    while (op_queue.size() != 0 || start) @(posedge clk);
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (n_err == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
